FILE: hdl/fhp_pkg.sv
// Shared types, constants and register codes for the fire heat propagation block.
package fhp_pkg;

  // Field widths.
  localparam int HEAT_W   = 8;
  localparam int GAIN_W   = 16;
  localparam int BONUS_W  = 4;
  localparam int RL_W     = 11;
  localparam int SUM_W    = HEAT_W + 2;
  localparam int PROD_W   = SUM_W + GAIN_W;

  // Line buffer depth default.
  localparam int LINE_MAX_DEF = 1024;

  // Heat ceiling, also the heat of a fire source.
  localparam logic [HEAT_W-1:0] HEAT_MAX = 8'd255;

  // Configuration port.
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_GAIN       = 2'd0,
    REG_BONUS      = 2'd1,
    REG_ROW_LENGTH = 2'd2,
    REG_NONE       = 2'd3
  } reg_idx_t;

  // Register reset values.
  localparam logic [GAIN_W-1:0]  GAIN_RST       = 16'd20480;
  localparam logic [BONUS_W-1:0] BONUS_RST      = 4'd2;
  localparam logic [RL_W-1:0]    ROW_LENGTH_RST = 11'd256;

  // Register file contents handed to the datapath.
  typedef struct packed {
    logic [GAIN_W-1:0]  gain;
    logic [BONUS_W-1:0] bonus;
    logic [RL_W-1:0]    row_length;
  } cfg_t;

endpackage

FILE: hdl/fhp_cfg_regs.sv
// APB-style configuration registers for the fire heat propagation block.
module fhp_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fhp_pkg::PADDR_W-1:0] paddr,
  input  logic [fhp_pkg::PDATA_W-1:0] pwdata,
  output logic [fhp_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output fhp_pkg::cfg_t               cfg
);

  fhp_pkg::cfg_t     cfg_r;
  fhp_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx    = fhp_pkg::reg_idx_t'(paddr[fhp_pkg::PADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Register writes on the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain       <= fhp_pkg::GAIN_RST;
      cfg_r.bonus      <= fhp_pkg::BONUS_RST;
      cfg_r.row_length <= fhp_pkg::ROW_LENGTH_RST;
    end else if (wr_en) begin
      case (idx)
        fhp_pkg::REG_GAIN:       cfg_r.gain       <= pwdata[fhp_pkg::GAIN_W-1:0];
        fhp_pkg::REG_BONUS:      cfg_r.bonus      <= pwdata[fhp_pkg::BONUS_W-1:0];
        fhp_pkg::REG_ROW_LENGTH: cfg_r.row_length <= pwdata[fhp_pkg::RL_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    case (idx)
      fhp_pkg::REG_GAIN:       prdata = fhp_pkg::PDATA_W'(cfg_r.gain);
      fhp_pkg::REG_BONUS:      prdata = fhp_pkg::PDATA_W'(cfg_r.bonus);
      fhp_pkg::REG_ROW_LENGTH: prdata = fhp_pkg::PDATA_W'(cfg_r.row_length);
      default:                 prdata = '0;
    endcase
  end

endmodule

FILE: hdl/fhp_line_mem.sv
// Heat line buffer: one write port and two registered read ports.
module fhp_line_mem #(
  parameter int DEPTH  = fhp_pkg::LINE_MAX_DEF,
  parameter int ADDR_W = $clog2(fhp_pkg::LINE_MAX_DEF)
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [ADDR_W-1:0]          wr_addr,
  input  logic [fhp_pkg::HEAT_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [ADDR_W-1:0]          rd_addr_a,
  input  logic [ADDR_W-1:0]          rd_addr_b,
  output logic [fhp_pkg::HEAT_W-1:0] rd_data_a,
  output logic [fhp_pkg::HEAT_W-1:0] rd_data_b
);

  logic [fhp_pkg::HEAT_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read ports return the contents before a same-edge write.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

FILE: hdl/fhp_heat_calc.sv
// New heat of one pixel: scaled neighbour sum plus bonus, saturated.
module fhp_heat_calc (
  input  logic [fhp_pkg::HEAT_W-1:0]  left_heat,
  input  logic [fhp_pkg::HEAT_W-1:0]  below_heat,
  input  logic [fhp_pkg::HEAT_W-1:0]  right_heat,
  input  logic [fhp_pkg::GAIN_W-1:0]  gain,
  input  logic [fhp_pkg::BONUS_W-1:0] bonus,
  input  logic                        rand_hit,
  output logic [fhp_pkg::HEAT_W-1:0]  heat
);

  localparam int SCL_W = fhp_pkg::PROD_W - fhp_pkg::GAIN_W;

  logic [fhp_pkg::SUM_W-1:0]  sum;
  logic [fhp_pkg::PROD_W-1:0] prod;
  logic [SCL_W-1:0]           scaled;
  logic [SCL_W:0]             total;

  // Sum of the three neighbours below, scaled by the Q0.16 gain.
  assign sum    = fhp_pkg::SUM_W'(left_heat) + fhp_pkg::SUM_W'(below_heat)
                + fhp_pkg::SUM_W'(right_heat);
  assign prod   = fhp_pkg::PROD_W'(sum) * fhp_pkg::PROD_W'(gain);
  assign scaled = prod[fhp_pkg::PROD_W-1:fhp_pkg::GAIN_W];

  // Random bonus, then clip to the heat range.
  assign total = (SCL_W + 1)'(scaled) + (rand_hit ? (SCL_W + 1)'(bonus) : '0);
  assign heat  = (total > (SCL_W + 1)'(fhp_pkg::HEAT_MAX)) ? fhp_pkg::HEAT_MAX
                                                          : total[fhp_pkg::HEAT_W-1:0];

endmodule

FILE: hdl/fire_heat_propagation.sv
// Top level of the fire heat propagation block: pixel pipeline around the line buffer.
//
// Pixels arrive bottom row first, left to right, and each input word gives exactly one
// output word (the new heat and a last-of-row flag). It takes one pixel per cycle
// while out_stall is low; a result passes through the second stage and the output
// register. The line buffer reads the below and below-right entries of each accepted
// pixel and writes back its new heat as it leaves the second stage; a write on the
// edge of a later pixel's read is forwarded. No clearing pass is needed after reset: a
// fill count of written columns makes unwritten entries read as zero. Configuration is
// to be written through the APB-style port only while idle; this is not enforced.
module fire_heat_propagation #(
  parameter int LINE_MAX = fhp_pkg::LINE_MAX_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Input channel.
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_seed_below,
  input  logic                        in_rand_hit,
  input  logic                        in_frame_start,
  // Result channel.
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [fhp_pkg::HEAT_W-1:0]  out_heat,
  output logic                        out_row_last,
  // Configuration port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fhp_pkg::PADDR_W-1:0] paddr,
  input  logic [fhp_pkg::PDATA_W-1:0] pwdata,
  output logic [fhp_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int ADDR_W = $clog2(LINE_MAX);
  localparam int CMP_W  = (ADDR_W + 1 > fhp_pkg::RL_W) ? ADDR_W + 1 : fhp_pkg::RL_W;

  fhp_pkg::cfg_t cfg;

  // Column tracking state.
  logic [ADDR_W-1:0] column_r;
  logic              first_row_r;
  logic [ADDR_W:0]   fill_r;

  // Second stage: the pixel whose buffer reads are in flight.
  logic                       s1_valid_r;
  logic [ADDR_W-1:0]          s1_col_r;
  logic                       s1_col0_r;
  logic                       s1_last_r;
  logic                       s1_first_r;
  logic                       s1_seed_r;
  logic                       s1_hit_r;
  logic                       s1_fwd_b_r;
  logic                       s1_fwd_r_r;
  logic                       s1_in_b_r;
  logic                       s1_in_r_r;
  logic [fhp_pkg::HEAT_W-1:0] fwd_heat_r;
  logic [fhp_pkg::HEAT_W-1:0] left_heat_r;

  // Output register.
  logic                       out_valid_r;
  logic [fhp_pkg::HEAT_W-1:0] out_heat_r;
  logic                       out_last_r;

  // Handshake.
  logic in_acc;
  logic s1_adv;

  // First stage signals.
  logic [ADDR_W-1:0] col_s0;
  logic              first_s0;
  logic [CMP_W-1:0]  rl_ext;
  logic [CMP_W-1:0]  eff_len;
  logic [CMP_W-1:0]  col_next;
  logic              last_s0;
  logic [ADDR_W-1:0] right_addr;

  // Second stage signals.
  logic [fhp_pkg::HEAT_W-1:0] rd_below;
  logic [fhp_pkg::HEAT_W-1:0] rd_right;
  logic [fhp_pkg::HEAT_W-1:0] mem_below;
  logic [fhp_pkg::HEAT_W-1:0] mem_right;
  logic [fhp_pkg::HEAT_W-1:0] below_heat;
  logic [fhp_pkg::HEAT_W-1:0] left_heat;
  logic [fhp_pkg::HEAT_W-1:0] right_heat;
  logic [fhp_pkg::HEAT_W-1:0] new_heat;
  logic [CMP_W-1:0]           s1_col_next;

  fhp_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Pipeline flow: the second stage moves on when the output register frees up.
  assign s1_adv    = s1_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall  = s1_valid_r & ~s1_adv;
  assign in_acc    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_heat  = out_heat_r;
  assign out_row_last = out_last_r;

  // Column, row end and read addresses of the incoming pixel.
  assign col_s0     = in_frame_start ? '0 : column_r;
  assign first_s0   = in_frame_start | first_row_r;
  assign rl_ext     = CMP_W'(cfg.row_length);
  assign eff_len    = (rl_ext > CMP_W'(LINE_MAX)) ? CMP_W'(LINE_MAX) : rl_ext;
  assign col_next   = CMP_W'(col_s0) + CMP_W'(1);
  assign last_s0    = (col_next >= eff_len);
  assign right_addr = col_s0 + ADDR_W'(1);

  fhp_line_mem #(
    .DEPTH  (LINE_MAX),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk       (clk),
    .wr_en     (s1_adv),
    .wr_addr   (s1_col_r),
    .wr_data   (new_heat),
    .rd_en     (in_acc),
    .rd_addr_a (col_s0),
    .rd_addr_b (right_addr),
    .rd_data_a (rd_below),
    .rd_data_b (rd_right)
  );

  // Buffered neighbours: forwarded, read back, or zero where never written.
  assign mem_below  = s1_fwd_b_r ? fwd_heat_r : (s1_in_b_r ? rd_below : '0);
  assign mem_right  = s1_fwd_r_r ? fwd_heat_r : (s1_in_r_r ? rd_right : '0);
  assign below_heat = s1_seed_r ? fhp_pkg::HEAT_MAX : (s1_first_r ? '0 : mem_below);
  assign left_heat  = s1_col0_r ? '0 : left_heat_r;
  assign right_heat = (s1_last_r | s1_first_r) ? '0 : mem_right;
  assign s1_col_next = CMP_W'(s1_col_r) + CMP_W'(1);

  fhp_heat_calc u_calc (
    .left_heat  (left_heat),
    .below_heat (below_heat),
    .right_heat (right_heat),
    .gain       (cfg.gain),
    .bonus      (cfg.bonus),
    .rand_hit   (s1_hit_r),
    .heat       (new_heat)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r    <= '0;
      first_row_r <= 1'b1;
      fill_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      left_heat_r <= '0;
    end else begin
      if (in_acc) begin
        column_r    <= last_s0 ? '0 : col_next[ADDR_W-1:0];
        first_row_r <= last_s0 ? 1'b0 : first_s0;
      end
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_valid & ~out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        left_heat_r <= below_heat;
        if (s1_col_next > CMP_W'(fill_r)) begin
          fill_r <= s1_col_next[ADDR_W:0];
        end
      end
    end
  end

  // Second stage payload, with forwarding of a write on the same edge as the reads.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_col_r   <= col_s0;
      s1_col0_r  <= (col_s0 == '0);
      s1_last_r  <= last_s0;
      s1_first_r <= first_s0;
      s1_seed_r  <= in_seed_below;
      s1_hit_r   <= in_rand_hit;
      s1_fwd_b_r <= s1_adv & (s1_col_r == col_s0);
      s1_fwd_r_r <= s1_adv & (s1_col_r == right_addr);
      s1_in_b_r  <= (CMP_W'(col_s0) < CMP_W'(fill_r));
      s1_in_r_r  <= (CMP_W'(right_addr) < CMP_W'(fill_r));
      fwd_heat_r <= new_heat;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_heat_r <= new_heat;
      out_last_r <= s1_last_r;
    end
  end

endmodule
